/* sv/dotted_decimal_address_parser_core_assert.svh */
// Assertion macros for the dotted-decimal address parser checker.
`ifndef DOTTED_DECIMAL_ADDRESS_PARSER_CORE_ASSERT_SVH
`define DOTTED_DECIMAL_ADDRESS_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define DDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dda assertion failed");

// Next-cycle implication.
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dda assertion failed");

`endif

/* sv/dda_pkg.sv */
// Shared types and constants of the dotted-decimal address parser.
package dda_pkg;

   localparam int CHAR_W = 8;
   localparam int ADDR_W = 32;

   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [1:0] DOTS_NONE  = 2'd0;
   localparam logic [1:0] DOTS_ONE   = 2'd1;
   localparam logic [1:0] DOTS_TWO   = 2'd2;
   localparam logic [1:0] DOTS_THREE = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] character;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] address;
      logic              malformed;
   } result_type;

endpackage

/* sv/dda_in_stage.sv */
// Input register for one address character.
module dda_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dda_pkg::CHAR_W-1:0] req_tdata,
   input  logic                       take,
   output dda_pkg::item_type          item
);
   import dda_pkg::*;

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
      end
   end

   assign item.valid     = valid_ff;
   assign item.character = char_ff;

endmodule

/* sv/dda_parse.sv */
// Parse state: decimal accumulator, dot count, stored parts and packing.
module dda_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  dda_pkg::item_type    item,
   input  logic                 out_space,
   output logic                 take,
   output dda_pkg::result_type  result
);
   import dda_pkg::*;

   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic [1:0]        dots_ff, dots_in;
   logic              err_ff, err_in;
   logic [ADDR_W-1:0] part0_ff;
   logic [23:0]       part1_ff;
   logic [15:0]       part2_ff;
   logic              is_nul, is_digit, is_dot;
   logic [3:0]        digit;
   logic [ADDR_W-1:0] packed_addr;

   assign is_nul   = (item.character == CHAR_NUL);
   assign is_dot   = (item.character == CHAR_DOT);
   assign is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
   assign digit    = item.character[3:0];

   assign take = item.valid && (!is_nul || out_space);

   always_comb begin
      acc_in  = acc_ff;
      dots_in = dots_ff;
      err_in  = err_ff;
      if (take) begin
         if (is_nul) begin
            acc_in  = '0;
            dots_in = DOTS_NONE;
            err_in  = 1'b0;
         end else if (!err_ff) begin
            if (is_digit) begin
               acc_in = {acc_ff[ADDR_W-4:0], 3'b000} + {acc_ff[ADDR_W-2:0], 1'b0}
                        + {{(ADDR_W-4){1'b0}}, digit};
            end else if (is_dot) begin
               if (dots_ff == DOTS_THREE) begin
                  err_in = 1'b1;
               end else begin
                  dots_in = dots_ff + 2'd1;
                  acc_in  = '0;
               end
            end else begin
               err_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         dots_ff <= DOTS_NONE;
         err_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         dots_ff <= dots_in;
         err_ff  <= err_in;
      end
   end

   // store the closed part at the slot named by the dot count
   always_ff @(posedge clock) begin
      if (take && !is_nul && !err_ff && is_dot) begin
         unique case (dots_ff)
            DOTS_NONE:  part0_ff <= acc_ff;
            DOTS_ONE:   part1_ff <= acc_ff[23:0];
            DOTS_TWO:   part2_ff <= acc_ff[15:0];
            DOTS_THREE: ;
         endcase
      end
   end

   always_comb begin
      unique case (dots_ff)
         DOTS_THREE: packed_addr = {acc_ff[7:0], 24'h0} | {part2_ff, 16'h0}
                                   | {part1_ff, 8'h0} | part0_ff;
         DOTS_TWO:   packed_addr = {acc_ff[7:0], 24'h0} | {part1_ff, 8'h0} | part0_ff;
         DOTS_ONE:   packed_addr = {acc_ff[7:0], 24'h0} | part0_ff;
         DOTS_NONE:  packed_addr = {acc_ff[7:0], 24'h0};
      endcase
   end

   assign result.valid     = take && is_nul;
   assign result.address   = err_ff ? '0 : packed_addr;
   assign result.malformed = err_ff;

endmodule

/* sv/dda_out_stage.sv */
// Result register holding one packed address word.
module dda_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  dda_pkg::result_type        result,
   output logic                       out_space,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dda_pkg::ADDR_W-1:0] rsp_tdata,
   output logic [0:0]                 rsp_tuser
);
   import dda_pkg::*;

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_ff;
   logic              bad_ff;

   assign out_space = !valid_ff || rsp_tready;
   assign valid_in  = result.valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         addr_ff <= result.address;
         bad_ff  <= result.malformed;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = addr_ff;
   assign rsp_tuser[0] = bad_ff;

endmodule

/* sv/dotted_decimal_address_parser_core.sv */
// Top level of the dotted-decimal address parser.
// Takes one address character per word and accepts a new word every cycle
// unless a terminator waits for room in the result register (sustained rate
// one character per clock). A zero character closes the string and yields one
// result word: the character is held in the input register, then the decimal
// multiply-by-ten-and-add, dot handling and address packing land in the result
// register. The input side keeps taking characters while a finished result
// waits; only a terminator waits for room in the result register. Malformed
// strings return address 0 with the flag set.
module dotted_decimal_address_parser_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dda_pkg::CHAR_W-1:0] req_tdata,   // [7:0] character
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [dda_pkg::ADDR_W-1:0] rsp_tdata,   // [31:0] address
   output logic [0:0]                 rsp_tuser    // [0] malformed
);
   import dda_pkg::*;

   item_type   item;
   result_type result;
   logic       take;
   logic       out_space;

   dda_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item       (item)
   );

   dda_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .out_space (out_space),
      .take      (take),
      .result    (result)
   );

   dda_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* sv/dda_checker.sv */
// Port-level checker for the dotted-decimal address parser, bound to the top.
`include "dotted_decimal_address_parser_core_assert.svh"

module dda_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [dda_pkg::CHAR_W-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [dda_pkg::ADDR_W-1:0] rsp_tdata,
   input logic [0:0]                 rsp_tuser
);
   import dda_pkg::*;

   logic unused_in;
   assign unused_in = req_tvalid ^ req_tready ^ (^req_tdata);

   // hold a stalled result word
   `DDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // malformed strings report a zero address
   `DDA_ASSERT_NOW(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata == '0)

   // drop any pending result on reset
   `DDA_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind dotted_decimal_address_parser_core dda_checker u_dda_checker (.*);

/* tb/tb_dotted_decimal_address_parser_core.sv */
// Self-checking testbench for the dotted-decimal address parser: character stream in, address out.
module tb_dotted_decimal_address_parser_core;
   import dda_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CALM_TAIL   = 150;
   localparam int RANDOM_CHARS = 1730;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      bit                hold;
   } text_char_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              malformed;
   } parsed_addr_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [CHAR_W-1:0]   req_tdata = CHAR_NUL;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [ADDR_W-1:0]   rsp_tdata;
   logic [0:0]          rsp_tuser;

   text_char_type   text_q[$];
   parsed_addr_type addr_q[$];
   bit              hold_pending = 1'b0;
   bit              calm = 1'b0;
   int              send_gap = 0;
   int              take_stall = 0;
   int              owed = 0;
   int              errors = 0;
   int              chars_taken = 0;
   int              addrs_checked = 0;
   int              malformed_checked = 0;
   int              cycles = 0;

   // parser state as predicted
   logic [ADDR_W-1:0] addr_acc;
   logic [1:0]        dots_seen;
   logic [ADDR_W-1:0] closed_part[3];
   bit                text_bad;

   dotted_decimal_address_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic clear_parser();
      addr_acc = '0;
      dots_seen = DOTS_NONE;
      closed_part[0] = '0;
      closed_part[1] = '0;
      closed_part[2] = '0;
      text_bad = 1'b0;
   endtask

   task automatic advance_parser(input logic [CHAR_W-1:0] c, output bit done,
                                 output parsed_addr_type res);
      done = 1'b0;
      res = '0;
      if (c == CHAR_NUL) begin
         done = 1'b1;
         if (text_bad) begin
            res.malformed = 1'b1;
         end else begin
            case (dots_seen)
               DOTS_THREE: res.address = (addr_acc << 24) | (closed_part[2] << 16) |
                                         (closed_part[1] << 8) | closed_part[0];
               DOTS_TWO:   res.address = (addr_acc << 24) | (closed_part[1] << 8) |
                                         closed_part[0];
               DOTS_ONE:   res.address = (addr_acc << 24) | closed_part[0];
               default:    res.address = addr_acc << 24;
            endcase
         end
         clear_parser();
      end else if (!text_bad) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            addr_acc = addr_acc * 10 + (c - CHAR_ZERO);
         end else if (c == CHAR_DOT) begin
            if (dots_seen == DOTS_THREE) begin
               text_bad = 1'b1;
            end else begin
               closed_part[dots_seen] = addr_acc;
               dots_seen = dots_seen + 2'd1;
               addr_acc = '0;
            end
         end else begin
            text_bad = 1'b1;
         end
      end
   endtask

   task automatic add_char(input logic [CHAR_W-1:0] c);
      text_char_type t;
      t.ch = c;
      t.hold = hold_pending;
      hold_pending = 1'b0;
      text_q.push_back(t);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
   endtask

   task automatic add_decimal(input longint unsigned v);
      byte digits[$];
      do begin
         digits.push_front(byte'(CHAR_ZERO + v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) add_char(digits[i]);
   endtask

   task automatic add_part();
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
         add_decimal($urandom_range(0, 255));
      end else if (mode < 72) begin
         // empty part
      end else if (mode < 82) begin
         repeat ($urandom_range(1, 3)) add_char(CHAR_ZERO);
         add_decimal($urandom_range(0, 255));
      end else begin
         add_decimal({$urandom, $urandom} >> $urandom_range(0, 40));
      end
   endtask

   function automatic logic [CHAR_W-1:0] pick_bad_char();
      logic [CHAR_W-1:0] c;
      do begin
         c = CHAR_W'($urandom_range(1, 255));
      end while (c == CHAR_DOT || (c >= CHAR_ZERO && c <= CHAR_NINE));
      return c;
   endfunction

   task automatic add_random_string();
      int kind;
      int dots;
      int bad_at;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 8)) add_char(CHAR_W'($urandom_range(1, 255)));
      end else begin
         dots = (kind < 20) ? $urandom_range(4, 6) : $urandom_range(0, 3);
         bad_at = $urandom_range(0, dots);
         for (int k = 0; k <= dots; k++) begin
            add_part();
            if (kind < 30 && kind >= 20 && k == bad_at) add_char(pick_bad_char());
            if (k < dots) add_char(CHAR_DOT);
         end
      end
      add_char(CHAR_NUL);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d addresses still owed", cycles, addr_q.size());
         $display("dotted_decimal_address_parser_core regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : drive
      bit                nul_taken;
      logic              next_valid;
      logic [CHAR_W-1:0] next_data;
      int                gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= CHAR_NUL;
         send_gap   <= 0;
         calm       <= 1'b0;
      end else begin
         nul_taken  = req_tvalid && req_tready && req_tdata == CHAR_NUL;
         next_valid = req_tvalid && !req_tready;
         next_data  = req_tdata;
         gap        = send_gap;
         if (!next_valid) begin
            if (gap != 0) begin
               gap--;
            end else if (text_q.size() != 0 &&
                         (!text_q[0].hold || (owed == 0 && !nul_taken))) begin
               next_valid = 1'b1;
               next_data  = text_q[0].ch;
               void'(text_q.pop_front());
               if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 10);
            end
         end
         req_tvalid <= next_valid;
         req_tdata  <= next_data;
         send_gap   <= gap;
         calm       <= calm || text_q.size() < CALM_TAIL;
      end
   end

   always @(posedge clock) begin : observe
      int              inc;
      int              dec;
      int              stall;
      bit              done;
      parsed_addr_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_stall <= 0;
         owed       <= 0;
      end else begin
         inc = 0;
         dec = 0;
         if (rsp_tvalid && rsp_tready) begin
            dec = 1;
            if (addr_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected address word: expected none, actual %h malformed %b",
                        $time, rsp_tdata, rsp_tuser[0]);
            end else begin
               want = addr_q.pop_front();
               addrs_checked++;
               if (want.malformed) malformed_checked++;
               if (rsp_tdata !== want.address) begin
                  errors++;
                  $display("%0t: address mismatch: expected %h, actual %h",
                           $time, want.address, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.malformed) begin
                  errors++;
                  $display("%0t: malformed flag mismatch: expected %b, actual %b",
                           $time, want.malformed, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            chars_taken++;
            advance_parser(req_tdata, done, want);
            if (done) begin
               addr_q.push_back(want);
               inc = 1;
            end
         end
         owed <= owed + inc - dec;
         stall = take_stall;
         if (stall != 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 10);
         end
         take_stall <= stall;
      end
   end

   initial begin : main
      int strings;
      clear_parser();
      add_char(CHAR_NUL);
      add_text("1.23.4.5");
      add_char(CHAR_NUL);
      add_text("....");
      add_char(CHAR_NUL);
      add_char(CHAR_ZERO);
      add_char(8'hFF);
      add_char(CHAR_NINE);
      add_char(CHAR_NUL);
      add_text("67.8888888888");
      add_char(CHAR_NUL);
      strings = 0;
      while (text_q.size() < RANDOM_CHARS) begin
         strings++;
         hold_pending = (strings % 60 == 0);
         add_random_string();
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (text_q.size() != 0 || req_tvalid || addr_q.size() != 0);
      repeat (8) @(negedge clock);
      $display("parsed %0d characters into %0d addresses, %0d of them malformed",
               chars_taken, addrs_checked, malformed_checked);
      $display("stimulus mixed valid dotted text, extra dots, bad bytes and raw noise");
      if (errors == 0) begin
         $display("dotted_decimal_address_parser_core regression: pass");
      end else begin
         $display("dotted_decimal_address_parser_core regression: fail");
      end
      $finish;
   end

endmodule
